// ===== src/vms_pkg.sv =====
// Package for the von Mises equivalent stress pipeline.
// Holds the element index width and the tag that travels with each transaction.
// No dependencies.
`timescale 1ns / 1ps

package vms_pkg;

    localparam int INDEX_WIDTH = 20;

    // Valid bit and element index, carried alongside the data in every stage.
    typedef struct packed {
        logic                   valid;
        logic [INDEX_WIDTH-1:0] element;
    } t_tag;

endpackage

// ===== src/von_mises_equivalent_stress.sv =====
// Von Mises equivalent stress: floor(sqrt(sum of squared normal differences / 2
// + 3 * sum of squared shears)) for one element per transaction.
// Four arithmetic stages plus one square root stage per result bit lie between
// acceptance and o_strobe.
// Throughput: one transaction per cycle; busy never rises since the receiver cannot stall.
// Reset (synchronous, active low) clears every stage valid bit; no results are lost after it.
`timescale 1ns / 1ps

module von_mises_equivalent_stress
    import vms_pkg::*;
#(
    parameter int STRESS_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [STRESS_WIDTH-1:0] i_stress_xx,
    input  logic signed [STRESS_WIDTH-1:0] i_stress_yy,
    input  logic signed [STRESS_WIDTH-1:0] i_stress_zz,
    input  logic signed [STRESS_WIDTH-1:0] i_shear_yz,
    input  logic signed [STRESS_WIDTH-1:0] i_shear_xz,
    input  logic signed [STRESS_WIDTH-1:0] i_shear_xy,
    input  logic [INDEX_WIDTH-1:0]        i_element_index,
    output logic                          o_strobe,
    output logic [STRESS_WIDTH:0]         o_equivalent_stress,
    output logic [INDEX_WIDTH-1:0]        o_result_element
);

    localparam int W = STRESS_WIDTH;

    t_tag           w_in_tag;
    t_tag           w_sq_tag;
    t_tag           w_sum_tag;
    t_tag           w_out_tag;
    logic [2*W+1:0] w_norm_sq [3];
    logic [2*W-1:0] w_shear_sq [3];
    logic [2*W+1:0] w_half;

    assign busy = 1'b0;

    assign w_in_tag = {start & ~busy, i_element_index};

    vms_square #(.W(W)) u_square (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_in_tag),
        .i_sxx      (i_stress_xx),
        .i_syy      (i_stress_yy),
        .i_szz      (i_stress_zz),
        .i_syz      (i_shear_yz),
        .i_sxz      (i_shear_xz),
        .i_sxy      (i_shear_xy),
        .o_tag      (w_sq_tag),
        .o_norm_sq  (w_norm_sq),
        .o_shear_sq (w_shear_sq)
    );

    vms_sum #(.W(W)) u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_sq_tag),
        .i_norm_sq  (w_norm_sq),
        .i_shear_sq (w_shear_sq),
        .o_tag      (w_sum_tag),
        .o_half     (w_half)
    );

    vms_isqrt #(.N(W + 1)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_sum_tag),
        .i_radicand (w_half),
        .o_tag      (w_out_tag),
        .o_root     (o_equivalent_stress)
    );

    assign o_strobe         = w_out_tag.valid;
    assign o_result_element = w_out_tag.element;

endmodule

// ===== src/vms_square.sv =====
// Front end of the stress pipeline: normal stress differences, magnitudes and squares.
// Two register stages. Depends on vms_pkg.
`timescale 1ns / 1ps

module vms_square
    import vms_pkg::*;
#(
    parameter int W = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tag                i_tag,
    input  logic signed [W-1:0] i_sxx,
    input  logic signed [W-1:0] i_syy,
    input  logic signed [W-1:0] i_szz,
    input  logic signed [W-1:0] i_syz,
    input  logic signed [W-1:0] i_sxz,
    input  logic signed [W-1:0] i_sxy,
    output t_tag                o_tag,
    output logic [2*W+1:0]      o_norm_sq [3],
    output logic [2*W-1:0]      o_shear_sq [3]
);

    logic signed [W:0] n_diff [3];
    logic [W:0]        n_nmag [3];
    logic [W-1:0]      n_smag [3];
    logic signed [W-1:0] w_shear [3];

    logic [W:0]     r_nmag [3];
    logic [W-1:0]   r_smag [3];
    t_tag           r_tag1;
    t_tag           r_tag2;
    logic [2*W+1:0] r_nsq [3];
    logic [2*W-1:0] r_ssq [3];

    assign w_shear[0] = i_syz;
    assign w_shear[1] = i_sxz;
    assign w_shear[2] = i_sxy;

    always_comb begin
        n_diff[0] = {i_sxx[W-1], i_sxx} - {i_syy[W-1], i_syy};
        n_diff[1] = {i_syy[W-1], i_syy} - {i_szz[W-1], i_szz};
        n_diff[2] = {i_szz[W-1], i_szz} - {i_sxx[W-1], i_sxx};
        for (int k = 0; k < 3; k++) begin
            // The differences never reach -2^W, so the magnitude fits W+1 bits.
            n_nmag[k] = n_diff[k][W] ? (W+1)'(0) - n_diff[k] : n_diff[k];
            // The most negative shear value maps to 2^(W-1), which still fits.
            n_smag[k] = w_shear[k][W-1] ? W'(0) - w_shear[k] : w_shear[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
        for (int k = 0; k < 3; k++) begin
            r_nmag[k] <= n_nmag[k];
            r_smag[k] <= n_smag[k];
            r_nsq[k]  <= r_nmag[k] * r_nmag[k];
            r_ssq[k]  <= r_smag[k] * r_smag[k];
        end
    end

    assign o_tag      = r_tag2;
    assign o_norm_sq  = r_nsq;
    assign o_shear_sq = r_ssq;

endmodule

// ===== src/vms_sum.sv =====
// Middle of the stress pipeline: sums of the squares and the exact halving.
// Two register stages. Depends on vms_pkg.
`timescale 1ns / 1ps

module vms_sum
    import vms_pkg::*;
#(
    parameter int W = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_tag           i_tag,
    input  logic [2*W+1:0] i_norm_sq [3],
    input  logic [2*W-1:0] i_shear_sq [3],
    output t_tag           o_tag,
    output logic [2*W+1:0] o_half
);

    logic [2*W+2:0] n_half;

    t_tag           r_tag1;
    t_tag           r_tag2;
    logic [2*W+2:0] r_nsum;
    logic [2*W+1:0] r_ssum;
    logic [2*W+1:0] r_half;

    // The three differences sum to zero, so the normal sum is always even.
    assign n_half = {1'b0, r_nsum[2*W+2:1]} + {1'b0, r_ssum} + {r_ssum, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
        r_nsum <= {1'b0, i_norm_sq[0]} + {1'b0, i_norm_sq[1]} + {1'b0, i_norm_sq[2]};
        r_ssum <= {2'b00, i_shear_sq[0]} + {2'b00, i_shear_sq[1]}
                + {2'b00, i_shear_sq[2]};
        r_half <= n_half[2*W+1:0];
    end

    assign o_tag  = r_tag2;
    assign o_half = r_half;

endmodule

// ===== src/vms_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Restoring digit-by-digit method over a 2N-bit radicand. Depends on vms_pkg.
`timescale 1ns / 1ps

module vms_isqrt
    import vms_pkg::*;
#(
    parameter int N = 25
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_tag           i_tag,
    input  logic [2*N-1:0] i_radicand,
    output t_tag           o_tag,
    output logic [N-1:0]   o_root
);

    t_tag           r_tag  [N];
    logic [N+1:0]   r_rem  [N];
    logic [N-1:0]   r_root [N];
    logic [2*N-1:0] r_rad  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        t_tag           w_tag;
        logic [N+1:0]   w_rem;
        logic [N-1:0]   w_root;
        logic [2*N-1:0] w_rad;
        logic [N+1:0]   n_shift;
        logic [N+1:0]   n_trial;
        logic           n_ge;

        if (k == 0) begin : g_first
            assign w_tag  = i_tag;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_radicand;
        end else begin : g_next
            assign w_tag  = r_tag[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
        end

        // The partial remainder stays below 2^N until the last step, so its
        // top two bits can be dropped before the shift.
        always_comb begin
            n_shift = {w_rem[N-1:0], w_rad[2*N-1:2*N-2]};
            n_trial = {w_root, 2'b01};
            n_ge    = (n_shift >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].valid <= 1'b0;
            end else begin
                r_tag[k] <= w_tag;
            end
            r_rem[k]  <= n_ge ? n_shift - n_trial : n_shift;
            r_root[k] <= {w_root[N-2:0], n_ge};
            r_rad[k]  <= {w_rad[2*N-3:0], 2'b00};
        end
    end

    assign o_tag  = r_tag[N-1];
    assign o_root = r_root[N-1];

endmodule
